// ----- src/bbc_pkg.sv -----
// Shared types and constants for the block buffer cache.
// Used by every module in src; no dependencies.
package bbc_pkg;
	typedef enum logic [1:0] {
		ACT_READ    = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_PIN     = 2'd2,
		ACT_UNPIN   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_COUNT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  buffer_index;
	} req_t;

	typedef struct packed {
		logic [4:0] entry_index;
		logic       hit;
		logic       needs_fill;
		logic [1:0] status;
	} rsp_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic       lookup;    // compare phase of a read
		logic       commit;    // update phase
		action_t    action;
		logic [7:0] device;
		logic [31:0] block_number;
	} bbc_cmd_t;
endpackage

// ----- src/bbc_cell.sv -----
// One cache entry: tag, count, free flag and free age rank.
// Depends on bbc_pkg.
module bbc_cell #(
	parameter int RW   = 5,
	parameter int CW   = 6,
	parameter int N    = 32,
	parameter int IDX  = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bbc_pkg::bbc_cmd_t     cmd,
	input  logic                  sel,        // this entry is acted on at commit
	input  logic                  newest,     // entry goes to the free tail
	input  logic                  victim,     // miss retags this entry
	input  logic [RW-1:0]         moved_rank, // rank of the entry made newest
	input  logic                  age_shift,  // ranks above moved_rank drop
	output logic                  match,
	output logic                  free,
	output logic [RW-1:0]         rank,
	output logic [CW-1:0]         count,
	output logic                  valid
);
	import bbc_pkg::*;

	logic [7:0]    dev_q;
	logic [31:0]   blk_q;
	logic          valid_q;
	logic [CW-1:0] count_q;
	logic          free_q;
	logic [RW-1:0] rank_q;

	assign match = !free_q && dev_q == cmd.device && blk_q == cmd.block_number;
	assign free  = free_q;
	assign rank  = rank_q;
	assign count = count_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q   <= '0;
			blk_q   <= '0;
			valid_q <= 1'b0;
			count_q <= '0;
			free_q  <= 1'b1;
			rank_q  <= RW'(IDX);
		end else if (cmd.commit) begin
			if (victim) begin
				dev_q   <= cmd.device;
				blk_q   <= cmd.block_number;
				valid_q <= 1'b1;
				count_q <= CW'(1);
				free_q  <= 1'b0;
			end else if (sel) begin
				case (cmd.action)
					ACT_READ: begin
						count_q <= count_q + CW'(1);
						valid_q <= 1'b1;
					end
					ACT_PIN:     count_q <= count_q + CW'(1);
					ACT_RELEASE: count_q <= count_q - CW'(1);
					ACT_UNPIN:   count_q <= count_q - CW'(1);
					default:     count_q <= count_q;
				endcase
			end
			if (age_shift) begin
				if (newest) begin
					free_q <= 1'b1;
					rank_q <= RW'(N - 1);
				end else if (rank_q > moved_rank) begin
					rank_q <= rank_q - RW'(1);
				end
			end
		end
	end
endmodule

// ----- src/bbc_ctrl.sv -----
// Sequencer: lookup and commit in one state, then the output register.
// Depends on bbc_pkg.
module bbc_ctrl #(
	parameter int N  = 32,
	parameter int CW = 6,
	parameter int CMAX = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bbc_pkg::req_t     in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bbc_pkg::rsp_t     out_data,
	output bbc_pkg::bbc_cmd_t cmd,
	input  logic [N-1:0]      hit_vec,
	input  logic [N-1:0]      lru_vec,    // onehot oldest free entry
	input  logic [CW-1:0]     sel_count,
	input  logic              sel_valid,
	output logic [$clog2(N)-1:0] sel_idx,
	output logic              do_sel,
	output logic              do_victim,
	output logic              do_free
);
	import bbc_pkg::*;
	localparam int IW = $clog2(N);

	typedef enum logic [1:0] {IDLE, LOOK, DONE} state_t;
	state_t state_q;
	req_t   req_q;
	rsp_t   rsp_q;
	logic   out_valid_q;

	logic          any_hit, any_free, in_range;
	logic [IW-1:0] hit_idx, lru_idx;

	always_comb begin
		hit_idx = '0;
		lru_idx = '0;
		for (int i = N-1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = IW'(i);
			if (lru_vec[i]) lru_idx = IW'(i);
		end
	end
	assign any_hit  = |hit_vec;
	assign any_free = |lru_vec;
	assign in_range = 32'(req_q.buffer_index) < 32'(N);

	assign cmd.lookup       = state_q == LOOK;
	assign cmd.commit       = state_q == LOOK;
	assign cmd.action       = action_t'(req_q.action);
	assign cmd.device       = req_q.device;
	assign cmd.block_number = req_q.block_number;

	// entry targeted by the pending command
	always_comb begin
		if (req_q.action == ACT_READ) sel_idx = any_hit ? hit_idx : lru_idx;
		else sel_idx = IW'(req_q.buffer_index);
	end

	rsp_t     rsp_d;
	always_comb begin
		rsp_d     = '0;
		do_sel    = 1'b0;
		do_victim = 1'b0;
		do_free   = 1'b0;
		rsp_d.entry_index = req_q.buffer_index;
		rsp_d.status      = ST_OK;
		case (action_t'(req_q.action))
			ACT_READ: begin
				if (any_hit) begin
					rsp_d.entry_index = 5'(hit_idx);
					rsp_d.hit = 1'b1;
					if (32'(sel_count) >= 32'(CMAX)) rsp_d.status = ST_COUNT;
					else begin
						do_sel = 1'b1;
						rsp_d.needs_fill = !sel_valid;
					end
				end else if (any_free) begin
					rsp_d.entry_index = 5'(lru_idx);
					rsp_d.needs_fill  = 1'b1;
					do_victim = 1'b1;
				end else begin
					rsp_d.entry_index = '0;
					rsp_d.status = ST_NO_FREE;
				end
			end
			ACT_PIN: begin
				if (in_range) begin
					if (32'(sel_count) >= 32'(CMAX)) rsp_d.status = ST_COUNT;
					else do_sel = 1'b1;
				end
			end
			default: begin
				if (in_range) begin
					if (sel_count == '0) rsp_d.status = ST_COUNT;
					else begin
						do_sel = 1'b1;
						do_free = req_q.action == ACT_RELEASE && sel_count == CW'(1);
					end
				end
			end
		endcase
	end

	assign in_stall  = state_q != IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: if (in_valid) state_q <= LOOK;
				LOOK: begin
					rsp_q <= rsp_d;
					out_valid_q <= 1'b1;
					state_q <= DONE;
				end
				DONE: if (!out_stall) begin
					out_valid_q <= 1'b0;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_valid) req_q <= in_data;
	end
endmodule

// ----- src/block_buffer_cache_lru.sv -----
// Block buffer cache with LRU recycling of free entries.
// Channels: req (valid/stall, req_t) in, rsp (valid/stall, rsp_t) out.
// Each request gives exactly one response. A request is taken, compared
// against all cells in parallel on the next cycle and committed; the
// response is registered as the entries commit and held until taken.
// One request is in flight at a time: a new request is taken only after the
// lookup/commit step and the single output register, and only once the
// receiver has taken the response.
// While rsp_stall is high the response holds and req_stall stays high.
// Reset: all entries free with ranks equal to their index, counts zero,
// tags zero, contents invalid; no response pending.
// The ranks form a permutation; the oldest free entry is the free one of
// lowest rank, found by a parallel compare over the cells.
module block_buffer_cache_lru #(
	parameter int ENTRIES      = 32,
	parameter int REFCOUNT_MAX = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bbc_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bbc_pkg::rsp_t  rsp
);
	import bbc_pkg::*;
	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(REFCOUNT_MAX + 1);

	bbc_cmd_t        cmd;
	logic [ENTRIES-1:0] hit_vec, free_vec, valid_vec, lru_vec;
	logic [RW-1:0]   rank_a [ENTRIES];
	logic [CW-1:0]   count_a [ENTRIES];
	logic [RW-1:0]   sel_idx;
	logic            do_sel, do_victim, do_free;
	logic [ENTRIES-1:0] first_hit;

	// lowest index wins among matches
	always_comb begin
		first_hit = '0;
		for (int i = 0; i < ENTRIES; i++)
			if (hit_vec[i] && first_hit == '0) first_hit[i] = 1'b1;
	end

	// oldest free: free entry with no free entry of lower rank
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			lru_vec[i] = free_vec[i];
			for (int j = 0; j < ENTRIES; j++)
				if (free_vec[j] && rank_a[j] < rank_a[i]) lru_vec[i] = 1'b0;
		end
	end

	bbc_ctrl #(.N(ENTRIES), .CW(CW), .CMAX(REFCOUNT_MAX)) u_ctrl (
		.clk, .arst_n,
		.in_valid(req_valid), .in_stall(req_stall), .in_data(req),
		.out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(rsp),
		.cmd, .hit_vec(first_hit), .lru_vec,
		.sel_count(count_a[sel_idx]), .sel_valid(valid_vec[sel_idx]),
		.sel_idx, .do_sel, .do_victim, .do_free
	);

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		bbc_cell #(.RW(RW), .CW(CW), .N(ENTRIES), .IDX(g)) u_cell (
			.clk, .arst_n, .cmd,
			.sel(do_sel && sel_idx == RW'(g)),
			.newest(sel_idx == RW'(g)),
			.victim(do_victim && sel_idx == RW'(g)),
			.moved_rank(rank_a[sel_idx]),
			.age_shift(do_free),
			.match(hit_vec[g]), .free(free_vec[g]), .rank(rank_a[g]),
			.count(count_a[g]), .valid(valid_vec[g])
		);
	end
endmodule

// ----- src/bbc_checker.sv -----
// Port-level checks for block_buffer_cache_lru, bound to the top level.
// Depends on bbc_pkg.
module bbc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bbc_pkg::rsp_t rsp
);
	import bbc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_one_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one in flight");

	a_rsp_after: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> ##1 rsp_valid)
		else $error("response missing after transfer");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3 &&
			!(rsp.status == ST_NO_FREE && (rsp.hit || rsp.needs_fill)))
		else $error("inconsistent response fields");
endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
	.clk, .arst_n, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp
);

// ----- sim/block_buffer_cache_lru_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LRU block buffer cache.
// Needs bbc_pkg and block_buffer_cache_lru from src; a built-in cache model predicts each response.
module block_buffer_cache_lru_tb;
	import bbc_pkg::*;

	localparam int NUM_ENTRIES = 32;
	localparam int COUNT_MAX   = 63;
	localparam int RANDOM_ITEMS = 1550;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	block_buffer_cache_lru #(
		.ENTRIES(NUM_ENTRIES),
		.REFCOUNT_MAX(COUNT_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// cache model state
	logic [7:0]  mdl_dev[NUM_ENTRIES];
	logic [31:0] mdl_blk[NUM_ENTRIES];
	logic        mdl_valid[NUM_ENTRIES];
	int          mdl_count[NUM_ENTRIES];
	logic        mdl_free[NUM_ENTRIES];
	int          mdl_rank[NUM_ENTRIES];

	rsp_t pending_rsp[$];
	int   mismatches;
	bit   sending_done;
	bit   rx_busy_hold;
	bit   rx_no_idle;
	bit   tx_no_idle;

	// directed table: a fixed response is given where has_rsp is set
	typedef struct {
		req_t r;
		bit   has_rsp;
		rsp_t x;
	} row_t;
	row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void cache_clear();
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			mdl_dev[i] = '0;
			mdl_blk[i] = '0;
			mdl_valid[i] = 1'b0;
			mdl_count[i] = 0;
			mdl_free[i] = 1'b1;
			mdl_rank[i] = i;
		end
	endfunction

	function automatic rsp_t cache_access(req_t r);
		rsp_t o;
		int   bi;
		int   best;
		int   old;
		o = '0;
		bi = r.buffer_index;
		if (action_t'(r.action) == ACT_READ) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (!mdl_free[i] && mdl_dev[i] == r.device && mdl_blk[i] == r.block_number) begin
					o.entry_index = i[4:0];
					o.hit = 1'b1;
					if (mdl_count[i] >= COUNT_MAX) begin
						o.status = ST_COUNT;
						return o;
					end
					mdl_count[i]++;
					o.needs_fill = !mdl_valid[i];
					mdl_valid[i] = 1'b1;
					o.status = ST_OK;
					return o;
				end
			end
			best = -1;
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (mdl_free[i] && (best < 0 || mdl_rank[i] < mdl_rank[best]))
					best = i;
			if (best < 0) begin
				o.status = ST_NO_FREE;
				return o;
			end
			mdl_dev[best] = r.device;
			mdl_blk[best] = r.block_number;
			mdl_count[best] = 1;
			mdl_free[best] = 1'b0;
			mdl_valid[best] = 1'b1;
			o.entry_index = best[4:0];
			o.needs_fill = 1'b1;
			o.status = ST_OK;
			return o;
		end
		o.entry_index = r.buffer_index;
		o.status = ST_OK;
		if (bi >= NUM_ENTRIES)
			return o;
		if (action_t'(r.action) == ACT_PIN) begin
			if (mdl_count[bi] >= COUNT_MAX)
				o.status = ST_COUNT;
			else
				mdl_count[bi]++;
			return o;
		end
		if (mdl_count[bi] == 0) begin
			o.status = ST_COUNT;
			return o;
		end
		mdl_count[bi]--;
		if (action_t'(r.action) == ACT_RELEASE && mdl_count[bi] == 0) begin
			mdl_free[bi] = 1'b1;
			old = mdl_rank[bi];
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (mdl_rank[i] > old)
					mdl_rank[i]--;
			mdl_rank[bi] = NUM_ENTRIES - 1;
		end
		return o;
	endfunction

	function automatic req_t make_req(action_t a, logic [7:0] d, logic [31:0] b, logic [4:0] bi);
		req_t r;
		r.action = a;
		r.device = d;
		r.block_number = b;
		r.buffer_index = bi;
		return r;
	endfunction

	function automatic rsp_t make_rsp(logic [4:0] e, logic h, logic f, status_t s);
		rsp_t o;
		o.entry_index = e;
		o.hit = h;
		o.needs_fill = f;
		o.status = s;
		return o;
	endfunction

	function automatic void add_row(req_t r, bit has, rsp_t x);
		row_t w;
		w.r = r;
		w.has_rsp = has;
		w.x = x;
		dir_rows.push_back(w);
	endfunction

	// block numbers drawn from a small pool so hits are common, with full-range noise
	function automatic req_t rand_req();
		int   k;
		req_t r;
		k = $urandom_range(0, 99);
		r.device = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		r.block_number = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40));
		r.buffer_index = 5'($urandom);
		if (k < 45)
			r.action = ACT_READ;
		else if (k < 80)
			r.action = ACT_RELEASE;
		else if (k < 90)
			r.action = ACT_PIN;
		else
			r.action = ACT_UNPIN;
		return r;
	endfunction

	task automatic send(req_t r, bit has, rsp_t x);
		rsp_t p;
		p = cache_access(r);
		if (has && p !== x)
			$display("note: table row disagrees with model, act=%0d", r.action);
		pending_rsp.push_back(has ? x : p);
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic idle_sender();
		if (!tx_no_idle && $urandom_range(0, 99) < 37) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sending_done = 1'b0;
		rx_busy_hold = 1'b0;
		tx_no_idle = 1'b0;
		mismatches = 0;
		cache_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(make_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0), 1, make_rsp(5'd0, 0, 0, ST_COUNT));
		add_row(make_req(ACT_UNPIN, 8'h00, 32'h0, 5'd31), 1, make_rsp(5'd31, 0, 0, ST_COUNT));
		add_row(make_req(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0), 1, make_rsp(5'd0, 0, 1, ST_OK));
		add_row(make_req(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31), 1, make_rsp(5'd0, 1, 0, ST_OK));
		add_row(make_req(ACT_READ, 8'h00, 32'h0, 5'd0), 1, make_rsp(5'd1, 0, 1, ST_OK));
		add_row(make_req(ACT_PIN, 8'h00, 32'h0, 5'd1), 1, make_rsp(5'd1, 0, 0, ST_OK));
		add_row(make_req(ACT_UNPIN, 8'h00, 32'h0, 5'd1), 1, make_rsp(5'd1, 0, 0, ST_OK));
		add_row(make_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0), 0, '0);
		add_row(make_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0), 0, '0);
		add_row(make_req(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 5'd0), 0, '0);
		add_row(make_req(ACT_RELEASE, 8'h00, 32'h0, 5'd1), 0, '0);
		add_row(make_req(ACT_UNPIN, 8'h00, 32'h0, 5'd2), 0, '0);
		add_row(make_req(ACT_PIN, 8'h00, 32'h0, 5'd2), 0, '0);
		add_row(make_req(ACT_UNPIN, 8'h00, 32'h0, 5'd2), 0, '0);
		add_row(make_req(ACT_READ, 8'h5A, 32'hA5A5_5A5A, 5'd0), 0, '0);
		for (int i = 0; i < dir_rows.size(); i++)
			send(dir_rows[i].r, dir_rows[i].has_rsp, dir_rows[i].x);

		// drive two entries to the count ceiling: pin overflow on one, read overflow on the other
		for (int i = 0; i < COUNT_MAX + 1; i++)
			send(make_req(ACT_PIN, 8'h00, 32'h0, 5'd2), 0, '0);
		for (int i = 0; i < COUNT_MAX; i++)
			send(make_req(ACT_READ, 8'h5A, 32'hA5A5_5A5A, 5'd0), 0, '0);
		// fill every entry, then miss with nothing free
		for (int i = 0; i < NUM_ENTRIES + 1; i++)
			send(make_req(ACT_READ, 8'h77, 32'(1000 + i), 5'd0), 0, '0);
		for (int i = 0; i < NUM_ENTRIES; i++)
			send(make_req(ACT_RELEASE, 8'h00, 32'h0, 5'(i)), 0, '0);

		// sender pause until drained
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_no_idle = (n >= 300 && n < 500);
			rx_busy_hold = (n >= 800 && n < 820);
			idle_sender();
			send(rand_req(), 0, '0);
		end
		req_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver: random stall plus one long hold-off
	initial begin
		int hold;
		rsp_stall = 1'b1;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_busy_hold && hold == 0)
				hold = 200;
			if (hold > 1) begin
				hold--;
				rsp_stall <= 1'b1;
			end else if (rx_no_idle) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < 37);
			end
			if (hold == 1 && !rx_busy_hold)
				hold = 0;
		end
	end

	initial begin
		rx_no_idle = 1'b0;
		#30_000;
		rx_no_idle = 1'b1;
		#5_000;
		rx_no_idle = 1'b0;
	end

	// response check
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.entry_index !== want.entry_index || rsp.hit !== want.hit
						|| rsp.needs_fill !== want.needs_fill || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, rsp);
				end
			end
		end
	end

	initial begin
		wait (sending_done);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/bbc_pkg.sv
src/bbc_cell.sv
src/bbc_ctrl.sv
src/block_buffer_cache_lru.sv
src/bbc_checker.sv
sim/block_buffer_cache_lru_tb.sv
